@@ rtl/twvc_pkg.sv @@
// Package with types, constants and helper functions for the tag write value clamp.
`timescale 1ns / 1ps
package twvc_pkg;

  localparam int unsigned NameMaxDefault = 16;
  localparam int unsigned QueueDepth     = 4;

  localparam logic [7:0] SvcTagWrite = 8'h4D;
  localparam logic [7:0] SegSymbolic = 8'h91;
  localparam logic [7:0] TypeSint    = 8'hC2;
  localparam logic [7:0] TypeInt     = 8'hC3;
  localparam logic [7:0] TypeDint    = 8'hC4;
  localparam logic [7:0] TypeLint    = 8'hC5;
  localparam logic [7:0] TypeReal    = 8'hCA;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_MATCH = 2'd1,
    VERDICT_ERROR = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    REG_WATCHED_TYPE = 3'd0,
    REG_NAME_LENGTH  = 3'd1,
    REG_NAME_LOW     = 3'd2,
    REG_NAME_HIGH    = 3'd3,
    REG_MIN_VALUE    = 3'd4,
    REG_MAX_VALUE    = 3'd5
  } reg_index_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic       connected;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic [1:0] verdict;
    logic       clamped;
  } out_word_t;

  // Command from the front part: either one byte to pass or a held value to emit, whole or partial.
  typedef struct packed {
    logic        is_value;
    logic [7:0]  data_byte;
    logic        last;
    logic [1:0]  verdict;
    logic        clamped;
    logic [63:0] value;
    logic [3:0]  count;
    logic        value_eop;
    logic        value_match;
  } cmd_t;

  // Byte width of a type code, zero for types that cannot be clamped.
  function automatic logic [3:0] type_width(input logic [15:0] t);
    logic [3:0] w;
    w = 4'd0;
    if (t[15:8] == 8'h00) begin
      case (t[7:0])
        TypeSint: w = 4'd1;
        TypeInt:  w = 4'd2;
        TypeDint: w = 4'd4;
        TypeReal: w = 4'd4;
        TypeLint: w = 4'd8;
        default:  w = 4'd0;
      endcase
    end
    return w;
  endfunction

  // Sign extend w bytes and flip the top bit so unsigned order equals signed order.
  function automatic logic [63:0] biased(input logic [63:0] x, input logic [3:0] w);
    logic [63:0] r;
    case (w)
      4'd1:    r = {{56{x[7]}}, x[7:0]};
      4'd2:    r = {{48{x[15]}}, x[15:0]};
      4'd4:    r = {{32{x[31]}}, x[31:0]};
      default: r = x;
    endcase
    r[63] = ~r[63];
    return r;
  endfunction

  function automatic logic is_nan32(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] fkey(input logic [31:0] b);
    return b[31] ? ~b : (b | 32'h8000_0000);
  endfunction

  function automatic logic flt_less(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan32(a) || is_nan32(b)) r = 1'b0;
    else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) r = 1'b0;
    else r = fkey(a) < fkey(b);
    return r;
  endfunction

endpackage

@@ rtl/twvc_front.sv @@
// Front part: parses each packet byte, holds value bytes and issues commands.
`timescale 1ns / 1ps
module twvc_front #(
  parameter int unsigned NameMax = twvc_pkg::NameMaxDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  twvc_pkg::in_word_t in_word_i,
  input  logic [15:0]        watched_type_i,
  input  logic [4:0]         name_length_i,
  input  logic [63:0]        name_chars_low_i,
  input  logic [63:0]        name_chars_high_i,
  input  logic [63:0]        min_value_i,
  input  logic [63:0]        max_value_i,
  output logic               cmd_valid_o,
  output twvc_pkg::cmd_t     cmd_o,
  input  logic               cmd_stall_i
);
  import twvc_pkg::*;

  logic [9:0]  pos_q, pos_d;
  logic [7:0]  path_q, path_d;
  logic        hdr_q, hdr_d, nok_q, nok_d;
  logic [15:0] type_q, type_d;
  logic [63:0] held_q, held_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [1:0]  verd_q, verd_d;
  logic        clamp_q, clamp_d;

  // Working values of the current byte.
  logic        acc;
  logic [9:0]  p;
  logic [10:0] t;
  logic [3:0]  w;
  logic [7:0]  b;
  logic        lo_ok;
  logic [7:0]  nchar;
  logic [3:0]  ci;
  logic [63:0] hv;
  logic        below, above;
  logic        flush_old;
  logic [63:0] old_held;
  logic [3:0]  old_cnt;

  // The input waits while the queue stalls or while an old partial value is flushed ahead of it.
  assign in_stall_o = cmd_stall_i || flush_old;
  assign acc = in_valid_i && !cmd_stall_i;
  assign b = in_word_i.data_byte;

  // Name character lookup; names longer than sixteen never match, whatever NameMax is.
  always_comb begin
    ci = 4'(p - 10'd4);
    if (p - 10'd4 < 10'd8) nchar = name_chars_low_i[ci[2:0]*8 +: 8];
    else nchar = name_chars_high_i[ci[2:0]*8 +: 8];
  end

  always_comb begin
    pos_d = pos_q; path_d = path_q; hdr_d = hdr_q; nok_d = nok_q;
    type_d = type_q; held_d = held_q; cnt_d = cnt_q; verd_d = verd_q;
    clamp_d = clamp_q;
    flush_old = 1'b0;
    old_held = held_q;
    old_cnt = cnt_q;
    cmd_o = '0;
    cmd_valid_o = 1'b0;
    below = 1'b0;
    above = 1'b0;
    hv = held_q;
    lo_ok = 1'b0;
    w = 4'd0;
    t = '0;

    // A first byte mid-packet flushes any partial value unchanged.
    if (in_word_i.first && pos_q != 10'd0) begin
      if (verd_q == VERDICT_MATCH && cnt_q < type_width(type_q)) flush_old = 1'b1;
      pos_d = 10'd0;
    end
    p = pos_d;

    if (p == 10'd0) begin
      path_d = 8'd0; type_d = 16'd0; cnt_d = 4'd0; verd_d = VERDICT_NONE;
      held_d = 64'd0; nok_d = 1'b0; clamp_d = 1'b0;
      hdr_d = in_word_i.connected && b == SvcTagWrite;
    end else if (p == 10'd1) begin
      path_d = b;
    end
    if (p == 10'd2)
      nok_d = b == SegSymbolic && 32'(name_length_i) <= NameMax && name_length_i <= 5'd16;
    else if (p == 10'd3)
      nok_d = nok_d && b == 8'(name_length_i);
    else if (p >= 10'd4 && p < 10'd4 + 10'(name_length_i))
      nok_d = nok_d && b == nchar;

    t = 11'd2 + {2'b0, path_d, 1'b0};
    if ({1'b0, p} == t) type_d = {type_d[15:8], b};
    if ({1'b0, p} == t + 11'd1) begin
      type_d = {b, type_d[7:0]};
      if (hdr_d && nok_d && {path_d, 1'b0} >= 9'd2 + 9'(name_length_i) &&
          type_d == watched_type_i)
        verd_d = (type_width(type_d) != 4'd0) ? VERDICT_MATCH : VERDICT_ERROR;
      else
        verd_d = VERDICT_NONE;
    end
    w = type_width(type_d);

    if (verd_d == VERDICT_MATCH && {1'b0, p} >= t + 11'd4 && cnt_d < w) begin
      hv = held_d | (64'(b) << {cnt_d[2:0], 3'b000});
      cnt_d = cnt_d + 4'd1;
      held_d = hv;
      cmd_o.is_value = 1'b1;
      if (cnt_d == w) begin
        if (type_d == 16'(TypeReal)) begin
          below = flt_less(hv[31:0], min_value_i[31:0]);
          above = flt_less(max_value_i[31:0], hv[31:0]);
        end else begin
          below = biased(hv, w) < biased(min_value_i, w);
          above = biased(hv, w) > biased(max_value_i, w);
        end
        if (below) begin held_d = min_value_i; clamp_d = 1'b1; end
        else if (above) begin held_d = max_value_i; clamp_d = 1'b1; end
        cmd_o.value = held_d; cmd_o.count = w;
        cmd_o.value_eop = in_word_i.last; cmd_o.value_match = 1'b1;
        cmd_o.clamped = clamp_d;
        lo_ok = 1'b1;
      end else if (in_word_i.last) begin
        cmd_o.value = held_d; cmd_o.count = cnt_d;
        cmd_o.value_eop = 1'b1; cmd_o.value_match = 1'b0;
        lo_ok = 1'b1;
      end
    end else begin
      cmd_o.is_value = 1'b0;
      cmd_o.data_byte = b;
      cmd_o.last = in_word_i.last;
      cmd_o.verdict = (verd_d == VERDICT_MATCH && cnt_d < w) ? VERDICT_NONE : verd_d;
      cmd_o.clamped = clamp_d;
      lo_ok = 1'b1;
    end

    if (in_word_i.last) pos_d = 10'd0;
    else if (p < 10'd1023) pos_d = p + 10'd1;

    // The flush of an old partial value travels on its own in front of this byte.
    cmd_valid_o = in_valid_i && lo_ok;
    if (flush_old) begin
      cmd_o.is_value = 1'b1;
      cmd_o.value = old_held;
      cmd_o.count = old_cnt;
      cmd_o.value_eop = 1'b0;
      cmd_o.value_match = 1'b0;
    end
  end

  // The flush command takes the place of the current byte, which then re-enters.
  logic acc_eff;
  assign acc_eff = acc && !flush_old;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; path_q <= '0; hdr_q <= 1'b0; nok_q <= 1'b0; type_q <= '0;
      held_q <= '0; cnt_q <= '0; verd_q <= '0; clamp_q <= 1'b0;
    end else if (acc && flush_old) begin
      // Drop the old packet state; the byte is taken afterwards as position zero.
      pos_q <= '0; cnt_q <= '0; verd_q <= VERDICT_NONE;
    end else if (acc_eff) begin
      pos_q <= pos_d; path_q <= path_d; hdr_q <= hdr_d; nok_q <= nok_d;
      type_q <= type_d; held_q <= held_d; cnt_q <= cnt_d; verd_q <= verd_d;
      clamp_q <= clamp_d;
    end
  end

endmodule

@@ rtl/twvc_queue.sv @@
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module twvc_queue #(
  parameter int unsigned Depth = twvc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  twvc_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_take_i,
  output twvc_pkg::cmd_t rd_data_o
);
  import twvc_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t            mem_q [Depth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;
  logic            wr, rd;

  assign wr_stall_o = cnt_q == (Aw+1)'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_take_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + Aw'(1);
      if (rd) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end

endmodule

@@ rtl/twvc_back.sv @@
// Back part: plays out commands as output words, one byte per cycle while the output is not stalled.
`timescale 1ns / 1ps
module twvc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_take_o,
  input  twvc_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output twvc_pkg::out_word_t out_word_o
);
  import twvc_pkg::*;

  logic [3:0] idx_q, idx_d;
  logic       done;

  // Current byte of the command at the head.
  always_comb begin
    out_word_o = '0;
    done = 1'b1;
    if (cmd_i.is_value) begin
      out_word_o.out_byte = cmd_i.value[idx_q[2:0]*8 +: 8];
      done = idx_q + 4'd1 >= cmd_i.count;
      if (done && cmd_i.value_eop) begin
        out_word_o.end_of_packet = 1'b1;
        out_word_o.verdict = cmd_i.value_match ? VERDICT_MATCH : VERDICT_NONE;
        out_word_o.clamped = cmd_i.value_match && cmd_i.clamped;
      end
    end else begin
      out_word_o.out_byte = cmd_i.data_byte;
      out_word_o.end_of_packet = cmd_i.last;
      out_word_o.verdict = cmd_i.last ? cmd_i.verdict : VERDICT_NONE;
      out_word_o.clamped = cmd_i.last && cmd_i.clamped;
    end
  end

  // An empty value flush emits nothing.
  logic empty;
  assign empty = cmd_i.is_value && cmd_i.count == 4'd0;
  assign out_valid_o = cmd_valid_i && !empty;
  assign cmd_take_o = cmd_valid_i && (empty || (!out_stall_i && done));
  assign idx_d = cmd_take_o ? 4'd0 : ((out_valid_o && !out_stall_i) ? idx_q + 4'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else idx_q <= idx_d;
  end

endmodule

@@ rtl/tag_write_value_clamp.sv @@
// Top level of the tag write value clamp.
// A passing byte is registered in the command queue before it appears at the output.
// One byte per cycle when not stalled; the back part emits a value of w bytes one byte after another.
// A first byte in mid-packet while a value is still expected stalls the input while the partial value is flushed.
// Reset clears packet state, registers and the queue; registers reset to zero.
`timescale 1ns / 1ps
module tag_write_value_clamp #(
  parameter int unsigned NameMax = twvc_pkg::NameMaxDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  twvc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output twvc_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);
  import twvc_pkg::*;

  logic [15:0] wtype_q;
  logic [4:0]  nlen_q;
  logic [63:0] nlo_q, nhi_q, min_q, max_q;
  logic        fvalid, fstall, qvalid, qtake;
  cmd_t        fcmd, qcmd;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wtype_q <= '0; nlen_q <= '0; nlo_q <= '0; nhi_q <= '0; min_q <= '0; max_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WATCHED_TYPE: wtype_q <= cfg_data_i[15:0];
        REG_NAME_LENGTH:  nlen_q <= cfg_data_i[4:0];
        REG_NAME_LOW:     nlo_q <= cfg_data_i;
        REG_NAME_HIGH:    nhi_q <= cfg_data_i;
        REG_MIN_VALUE:    min_q <= cfg_data_i;
        REG_MAX_VALUE:    max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  twvc_front #(.NameMax(NameMax)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .watched_type_i(wtype_q), .name_length_i(nlen_q), .name_chars_low_i(nlo_q),
    .name_chars_high_i(nhi_q), .min_value_i(min_q), .max_value_i(max_q),
    .cmd_valid_o(fvalid), .cmd_o(fcmd), .cmd_stall_i(fstall)
  );

  twvc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fvalid), .wr_stall_o(fstall), .wr_data_i(fcmd),
    .rd_valid_o(qvalid), .rd_take_i(qtake), .rd_data_o(qcmd)
  );

  twvc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(qvalid), .cmd_take_o(qtake), .cmd_i(qcmd),
    .out_valid_o, .out_stall_i, .out_word_o
  );

endmodule

@@ rtl/twvc_checker.sv @@
// Port-level checker for the tag write value clamp, bound to the top level.
`timescale 1ns / 1ps
module twvc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input twvc_pkg::out_word_t out_word_i
);
  import twvc_pkg::*;

  // Verdict and clamp flag only appear on the final word of a packet.
  a_verdict_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_word_i.end_of_packet |-> out_word_i.verdict == VERDICT_NONE)
    else $error("verdict outside end of packet");
  a_clamp_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.clamped |-> out_word_i.verdict == VERDICT_MATCH)
    else $error("clamp without match");
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_word_i.verdict != 2'd3)
    else $error("bad verdict code");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled word changed");

endmodule

bind tag_write_value_clamp twvc_checker u_checker (
  .clk_i, .rst_ni, .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the tag write value clamp: byte stream stimulus with a local predictor.
`timescale 1ns / 1ps
module tb_top;
  import twvc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned Phases     = 8;
  localparam int unsigned PhaseBytes = 36;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  tag_write_value_clamp dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Shadow of the configuration registers.
  logic [15:0] watch_type;
  logic [4:0]  tag_len;
  logic [63:0] chars_lo, chars_hi, bound_min, bound_max;

  // Shadow of the packet state.
  int unsigned pkt_pos, path_len;
  logic        hdr_good, name_good, clamp_done;
  logic [15:0] type_word;
  logic [63:0] value_acc;
  int unsigned value_cnt;
  verdict_e    pkt_verdict;

  out_word_t fresh_words[$];
  out_word_t pending_words[$];
  bit        failed;
  bit        no_idle;
  int unsigned cycles;

  // Clock and one reset at the start.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned width_of(input logic [15:0] t);
    case (t)
      16'h00C2: return 1;
      16'h00C3: return 2;
      16'h00C4: return 4;
      16'h00CA: return 4;
      16'h00C5: return 8;
      default:  return 0;
    endcase
  endfunction

  function automatic logic [63:0] order_key(input logic [63:0] x, input int unsigned w);
    logic [63:0] r;
    r = x;
    if (w < 8) begin
      r = x << (64 - 8 * w);
      r = $signed(r) >>> (64 - 8 * w);
    end
    return r ^ 64'h8000_0000_0000_0000;
  endfunction

  function automatic bit real_nan(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 0;
  endfunction

  function automatic bit real_below(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka, kb;
    if (real_nan(a) || real_nan(b)) return 1'b0;
    if (((a | b) & 32'h7FFF_FFFF) == 0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka < kb;
  endfunction

  function automatic logic [7:0] watched_char(input int unsigned i);
    if (i < 8) return chars_lo[8*i +: 8];
    if (i < 16) return chars_hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  function automatic void emit(input logic [7:0] b, input bit eop, input verdict_e v,
                               input bit c);
    out_word_t o;
    o.out_byte      = b;
    o.end_of_packet = eop;
    o.verdict       = eop ? v : VERDICT_NONE;
    o.clamped       = eop & c;
    fresh_words.push_back(o);
  endfunction

  function automatic void clear_packet();
    pkt_pos = 0; path_len = 0; type_word = 0; value_cnt = 0;
    pkt_verdict = VERDICT_NONE; value_acc = 0;
    hdr_good = 0; name_good = 0; clamp_done = 0;
  endfunction

  // Predict the output words caused by one accepted input word.
  function automatic void filter_byte(input in_word_t w);
    int unsigned p, t, wd, nl;
    bit below, above;
    verdict_e v;
    nl = tag_len;
    if (w.first && pkt_pos != 0) begin
      wd = width_of(type_word);
      if (pkt_verdict == VERDICT_MATCH && value_cnt < wd)
        for (int i = 0; i < value_cnt; i++) emit(value_acc[8*i +: 8], 0, VERDICT_NONE, 0);
      pkt_pos = 0;
    end
    p = pkt_pos;
    if (p == 0) begin
      clear_packet();
      hdr_good = w.connected && w.data_byte == SvcTagWrite;
    end else if (p == 1) begin
      path_len = w.data_byte;
    end
    if (p == 2) name_good = w.data_byte == SegSymbolic && nl <= 16;
    else if (p == 3) name_good = name_good && w.data_byte == nl;
    else if (p >= 4 && p < 4 + nl)
      name_good = name_good && w.data_byte == watched_char(p - 4);
    t = 2 + 2 * path_len;
    if (p == t) type_word[7:0] = w.data_byte;
    if (p == t + 1) begin
      type_word[15:8] = w.data_byte;
      if (hdr_good && name_good && 2 * path_len >= 2 + nl && type_word == watch_type)
        pkt_verdict = width_of(type_word) != 0 ? VERDICT_MATCH : VERDICT_ERROR;
      else
        pkt_verdict = VERDICT_NONE;
    end
    wd = width_of(type_word);
    if (pkt_verdict == VERDICT_MATCH && p >= t + 4 && value_cnt < wd) begin
      value_acc[8*value_cnt +: 8] = w.data_byte;
      value_cnt++;
      if (value_cnt == wd) begin
        // Min is tested before max, so crossed bounds favor min.
        if (type_word == {8'h00, TypeReal}) begin
          below = real_below(value_acc[31:0], bound_min[31:0]);
          above = real_below(bound_max[31:0], value_acc[31:0]);
        end else begin
          below = order_key(value_acc, wd) < order_key(bound_min, wd);
          above = order_key(value_acc, wd) > order_key(bound_max, wd);
        end
        if (below) begin
          value_acc = bound_min; clamp_done = 1;
        end else if (above) begin
          value_acc = bound_max; clamp_done = 1;
        end
        for (int i = 0; i < wd; i++)
          emit(value_acc[8*i +: 8], w.last && i + 1 == wd, VERDICT_MATCH, clamp_done);
      end else if (w.last) begin
        for (int i = 0; i < value_cnt; i++)
          emit(value_acc[8*i +: 8], i + 1 == value_cnt, VERDICT_NONE, 0);
      end
    end else begin
      v = pkt_verdict;
      if (v == VERDICT_MATCH && value_cnt < wd) v = VERDICT_NONE;
      emit(w.data_byte, w.last, v, clamp_done);
    end
    if (w.last) pkt_pos = 0;
    else if (pkt_pos < 1023) pkt_pos++;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall pattern.
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = gap_len();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected output word %h", out_word);
        failed = 1;
      end else begin
        e = pending_words.pop_front();
        if (out_word.out_byte !== e.out_byte) begin
          $error("out_byte expected %h got %h", e.out_byte, out_word.out_byte);
          failed = 1;
        end
        if (out_word.end_of_packet !== e.end_of_packet) begin
          $error("end_of_packet expected %b got %b", e.end_of_packet, out_word.end_of_packet);
          failed = 1;
        end
        if (out_word.verdict !== e.verdict) begin
          $error("verdict expected %0d got %0d", e.verdict, out_word.verdict);
          failed = 1;
        end
        if (out_word.clamped !== e.clamped) begin
          $error("clamped expected %b got %b", e.clamped, out_word.clamped);
          failed = 1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_e idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WATCHED_TYPE: watch_type = val[15:0];
      REG_NAME_LENGTH:  tag_len = val[4:0];
      REG_NAME_LOW:     chars_lo = val;
      REG_NAME_HIGH:    chars_hi = val;
      REG_MIN_VALUE:    bound_min = val;
      REG_MAX_VALUE:    bound_max = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send one word, starting at a falling edge; a typed expectation replaces the predicted one.
  // The task ends at the falling edge after acceptance with valid still high, so the
  // caller either sends the next word at once or drops valid.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    fresh_words.delete();
    filter_byte(w);
    if (typed) pending_words.push_back(want);
    else foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    @(negedge clk);
  endtask

  // Wait until idle, allowing for a value that is still being held.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_words.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$], input bit close, input bit conn);
    in_word_t w;
    out_word_t none;
    none = '0;
    foreach (bytes[i]) begin
      w.data_byte = bytes[i];
      w.first     = i == 0;
      w.last      = close && i == bytes.size() - 1;
      w.connected = conn;
      send_word(w, 0, none);
    end
  endtask

  function automatic logic [63:0] pick_value(input logic [15:0] t);
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '1;
      3: return '0;
      4: return t == {8'h00, TypeReal} ? 64'h7FC0_0001 : 64'h80;
      5: return t == {8'h00, TypeReal} ? 64'h8000_0000 : 64'h7F;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // One random packet: mostly a well-formed request for the watched tag.
  task automatic random_packet(inout int unsigned sent);
    logic [7:0] bytes[$];
    logic [15:0] t;
    logic [63:0] val;
    int unsigned nl, pw, vw, r;
    bit conn;
    r = $urandom_range(0, 99);
    conn = $urandom_range(0, 9) != 0;
    if (r < 10) begin
      repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom()));
      send_bytes(bytes, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      sent += bytes.size();
      return;
    end
    nl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : tag_len;
    pw = (2 + nl + 1) / 2 + $urandom_range(0, 1);
    if ($urandom_range(0, 11) == 0 && pw > 0) pw--;
    bytes.push_back($urandom_range(0, 11) == 0 ? 8'($urandom()) : SvcTagWrite);
    bytes.push_back(8'(pw));
    bytes.push_back($urandom_range(0, 15) == 0 ? 8'($urandom()) : SegSymbolic);
    bytes.push_back(8'(nl));
    while (bytes.size() < 2 + 2 * pw) begin
      if (bytes.size() - 4 < nl && $urandom_range(0, 19) != 0)
        bytes.push_back(watched_char(bytes.size() - 4));
      else
        bytes.push_back(8'($urandom()));
    end
    t = $urandom_range(0, 7) == 0 ? 16'($urandom()) : watch_type;
    bytes.push_back(t[7:0]);
    bytes.push_back(t[15:8]);
    bytes.push_back(8'($urandom()));
    bytes.push_back(8'($urandom()));
    vw = width_of(t);
    if (vw == 0) vw = $urandom_range(0, 4);
    val = pick_value(t);
    for (int i = 0; i < vw; i++) bytes.push_back(val[8*i +: 8]);
    repeat ($urandom_range(0, 2)) bytes.push_back(8'($urandom()));
    // Truncated packets end early.
    if ($urandom_range(0, 9) == 0) bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
    send_bytes(bytes, $urandom_range(0, 9) != 0, conn);
    sent += bytes.size();
  endtask

  // Directed rows: single bytes under reset settings, then SINT requests, one clamped and one cut off.
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } row_t;

  row_t rows[$];

  function automatic void add_row(input logic [7:0] b, input bit f, input bit l, input bit c,
                                  input bit typed, input out_word_t want);
    row_t r;
    r.w = '{data_byte: b, first: f, last: l, connected: c};
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  initial begin
    logic [7:0] req[$];
    out_word_t none;
    int unsigned sent;
    logic [15:0] types[8];
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WATCHED_TYPE;
    cfg_data = '0;
    failed = 0;
    no_idle = 0;
    cycles = 0;
    watch_type = 0; tag_len = 0; chars_lo = 0; chars_hi = 0; bound_min = 0; bound_max = 0;
    clear_packet();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings never match, so every byte passes with no verdict.
    add_row(8'h4D, 1, 1, 1, 1, '{8'h4D, 1'b1, VERDICT_NONE, 1'b0});
    add_row(8'hFF, 1, 1, 0, 1, '{8'hFF, 1'b1, VERDICT_NONE, 1'b0});
    add_row(8'h00, 0, 1, 1, 1, '{8'h00, 1'b1, VERDICT_NONE, 1'b0});
    add_row(8'hA5, 1, 0, 1, 1, '{8'hA5, 1'b0, VERDICT_NONE, 1'b0});
    add_row(8'h5A, 1, 1, 1, 1, '{8'h5A, 1'b1, VERDICT_NONE, 1'b0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
    drain();

    // Watch SINT tag "TAG" clamped to [-5, 5].
    write_reg(REG_WATCHED_TYPE, 64'h00C2);
    write_reg(REG_NAME_LENGTH, 64'd3);
    write_reg(REG_NAME_LOW, 64'h0047_4154);
    write_reg(REG_NAME_HIGH, 64'h0);
    write_reg(REG_MIN_VALUE, -64'sd5);
    write_reg(REG_MAX_VALUE, 64'sd5);
    rows.delete();
    req = '{8'h4D, 8'h03, 8'h91, 8'h03, 8'h54, 8'h41, 8'h47, 8'h00, 8'hC2, 8'h00,
            8'h01, 8'h00, 8'h80};
    foreach (req[i]) add_row(req[i], i == 0, i == req.size() - 1, 1, 0, none);
    rows[rows.size() - 1].typed = 0;
    // A first byte cuts into an unfinished packet that still expects its value.
    req = '{8'h4D, 8'h03, 8'h91, 8'h03, 8'h54, 8'h41, 8'h47, 8'h00, 8'hC2, 8'h00,
            8'h01, 8'h00};
    foreach (req[i]) add_row(req[i], i == 0, 0, 1, 0, none);
    add_row(8'h4D, 1, 1, 1, 0, none);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want);
    drain();

    // Random phases, each with fresh settings, extremes among them.
    types = '{16'h00C2, 16'h00C3, 16'h00C4, 16'h00C5, 16'h00CA, 16'h00C1, 16'hFFFF, 16'h00C3};
    for (int ph = 0; ph < Phases; ph++) begin
      no_idle = ph % 3 == 1;
      write_reg(REG_WATCHED_TYPE, ph == 6 ? 64'($urandom()) : 64'(types[ph]));
      write_reg(REG_NAME_LENGTH, ph == 2 ? 64'd16 : ph == 7 ? 64'($urandom_range(17, 31))
                                : 64'($urandom_range(0, 16)));
      write_reg(REG_NAME_LOW, {$urandom(), $urandom()});
      write_reg(REG_NAME_HIGH, ph == 3 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom(), $urandom()});
      case (ph % 4)
        0: begin
          write_reg(REG_MIN_VALUE, 64'h8000_0000_0000_0000);
          write_reg(REG_MAX_VALUE, 64'h7FFF_FFFF_FFFF_FFFF);
        end
        1: begin
          write_reg(REG_MIN_VALUE, 64'sd10);
          write_reg(REG_MAX_VALUE, -64'sd10);
        end
        default: begin
          write_reg(REG_MIN_VALUE, {$urandom(), $urandom()});
          write_reg(REG_MAX_VALUE, {$urandom(), $urandom()});
        end
      endcase
      if (ph == 4) begin
        write_reg(REG_MIN_VALUE, 64'hBF80_0000);
        write_reg(REG_MAX_VALUE, 64'h3F80_0000);
      end
      sent = 0;
      while (sent < PhaseBytes) random_packet(sent);
      drain();
    end

    if (pending_words.size() != 0) begin
      $error("pending words expected 0 got %0d", pending_words.size());
      failed = 1;
    end
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/twvc_pkg.sv
rtl/twvc_front.sv
rtl/twvc_queue.sv
rtl/twvc_back.sv
rtl/tag_write_value_clamp.sv
rtl/twvc_checker.sv
bench/tb_top.sv
